/* src/pip_pkg.sv */
// shared constants, types and helpers for the point-in-polygon crossing test
`default_nettype none
package pip_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RAY_BITS       = 16;
  localparam int SEEN_BITS      = 2;
  localparam int MIN_VERTICES   = 3;
  localparam int ADDR_BITS      = 3;
  localparam int DATA_BITS      = 32;

  localparam logic signed [RAY_BITS-1:0] RAY_RESET = 16'sd10000;

  // register index taken from the word address
  localparam logic [ADDR_BITS-3:0] REG_RAY_END_X = 1'b0;

  typedef enum logic [1:0] {
    ORI_COLLINEAR = 2'd0,
    ORI_CW        = 2'd1,
    ORI_CCW       = 2'd2
  } orient_t;

  // per-edge result of the intersection test
  typedef struct packed {
    logic hit;
    logic coll;
    logic on_box;
  } edge_flags_t;

  // control that travels with one item through the pipeline
  typedef struct packed {
    logic valid;
    logic has_edge;
    logic closing;
    logic last;
  } item_ctl_t;

  function automatic orient_t orient_of(input logic is_zero, input logic is_neg);
    orient_t o;
    if (is_zero) begin
      o = ORI_COLLINEAR;
    end else if (is_neg) begin
      o = ORI_CCW;
    end else begin
      o = ORI_CW;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* src/pip_front.sv */
// vertex tracking at the input: first and previous vertex, vertex count, stage-1 register
`default_nettype none
module pip_front
  import pip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic                         last_vertex,
  output item_ctl_t                         s1_ctl,
  output logic signed [COORD_BITS-1:0]      s1_px,
  output logic signed [COORD_BITS-1:0]      s1_py,
  output logic signed [COORD_BITS-1:0]      s1_vx,
  output logic signed [COORD_BITS-1:0]      s1_vy,
  output logic signed [COORD_BITS-1:0]      s1_prev_x,
  output logic signed [COORD_BITS-1:0]      s1_prev_y,
  output logic signed [COORD_BITS-1:0]      s1_first_x,
  output logic signed [COORD_BITS-1:0]      s1_first_y
);

  logic                         accept;
  logic [SEEN_BITS-1:0]         seen;
  logic [SEEN_BITS-1:0]         seen_next;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_x_next;
  logic signed [COORD_BITS-1:0] first_y_next;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic                         closing;

  assign accept = in_valid && adv;

  always_comb begin
    // count saturates at the minimum polygon size
    if (seen == SEEN_BITS'(MIN_VERTICES)) begin
      seen_next = seen;
    end else begin
      seen_next = seen + SEEN_BITS'(1);
    end
    if (seen == '0) begin
      first_x_next = vertex_x;
      first_y_next = vertex_y;
    end else begin
      first_x_next = first_x;
      first_y_next = first_y;
    end
    closing = last_vertex && (seen_next == SEEN_BITS'(MIN_VERTICES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else if (accept) begin
      if (last_vertex) begin
        seen    <= '0;
        first_x <= '0;
        first_y <= '0;
        prev_x  <= '0;
        prev_y  <= '0;
      end else begin
        seen    <= seen_next;
        first_x <= first_x_next;
        first_y <= first_y_next;
        prev_x  <= vertex_x;
        prev_y  <= vertex_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl.valid    <= accept;
      s1_ctl.has_edge <= (seen != '0);
      s1_ctl.closing  <= closing;
      s1_ctl.last     <= last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px      <= point_x;
      s1_py      <= point_y;
      s1_vx      <= vertex_x;
      s1_vy      <= vertex_y;
      s1_prev_x  <= prev_x;
      s1_prev_y  <= prev_y;
      s1_first_x <= first_x_next;
      s1_first_y <= first_y_next;
    end
  end

endmodule
`default_nettype wire

/* src/pip_edge.sv */
// one edge against the ray segment: product stage, then orientation and hit classification
`default_nettype none
module pip_edge
  import pip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  input  wire logic signed [RAY_BITS-1:0]   ex,
  output edge_flags_t                       flags
);

  localparam int CW = (COORD_BITS > RAY_BITS) ? COORD_BITS : RAY_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int OW = PW + 1;

  function automatic logic between(input logic signed [CW-1:0] v,
                                   input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b);
    return ((v >= a) && (v <= b)) || ((v >= b) && (v <= a));
  endfunction

  logic signed [CW-1:0] axe, aye, bxe, bye, pxe, pye, exe;
  logic signed [DW-1:0] d_by_ay, d_px_bx, d_bx_ax, d_py_by, d_ex_bx;
  logic signed [DW-1:0] d_ex_px, d_ay_py, d_by_py;
  orient_t              o3_c, o4_c;

  // stage 2
  logic signed [PW-1:0] m_a, m_b, m_c;
  logic                 w1, w2, w3, w4;
  orient_t              o3, o4;

  // stage 3 logic
  logic signed [OW-1:0] v1, v2;
  orient_t              o1, o2;
  logic                 meets;

  always_comb begin
    axe = CW'(ax);
    aye = CW'(ay);
    bxe = CW'(bx);
    bye = CW'(by);
    pxe = CW'(px);
    pye = CW'(py);
    exe = CW'(ex);
    d_by_ay = DW'(bye) - DW'(aye);
    d_px_bx = DW'(pxe) - DW'(bxe);
    d_bx_ax = DW'(bxe) - DW'(axe);
    d_py_by = DW'(pye) - DW'(bye);
    d_ex_bx = DW'(exe) - DW'(bxe);
    d_ex_px = DW'(exe) - DW'(pxe);
    d_ay_py = DW'(aye) - DW'(pye);
    d_by_py = DW'(bye) - DW'(pye);
    // ray ends share y, so these orientations reduce to minus a product of two signs
    o3_c = orient_of((d_ex_px == '0) || (d_ay_py == '0),
                     d_ex_px[DW-1] == d_ay_py[DW-1]);
    o4_c = orient_of((d_ex_px == '0) || (d_by_py == '0),
                     d_ex_px[DW-1] == d_by_py[DW-1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a <= PW'(d_by_ay) * PW'(d_px_bx);
      m_b <= PW'(d_bx_ax) * PW'(d_py_by);
      m_c <= PW'(d_by_ay) * PW'(d_ex_bx);
      w1  <= between(pxe, axe, bxe) && between(pye, aye, bye);
      w2  <= between(exe, axe, bxe) && between(pye, aye, bye);
      w3  <= between(axe, pxe, exe) && (aye == pye);
      w4  <= between(bxe, pxe, exe) && (bye == pye);
      o3  <= o3_c;
      o4  <= o4_c;
    end
  end

  always_comb begin
    v1 = OW'(m_a) - OW'(m_b);
    v2 = OW'(m_c) - OW'(m_b);
    o1 = orient_of(v1 == '0, v1[OW-1]);
    o2 = orient_of(v2 == '0, v2[OW-1]);
    meets = ((o1 != o2) && (o3 != o4)) ||
            ((o1 == ORI_COLLINEAR) && w1) ||
            ((o2 == ORI_COLLINEAR) && w2) ||
            ((o3 == ORI_COLLINEAR) && w3) ||
            ((o4 == ORI_COLLINEAR) && w4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags.hit    <= meets;
      flags.coll   <= (o1 == ORI_COLLINEAR);
      flags.on_box <= w1;
    end
  end

endmodule
`default_nettype wire

/* src/pip_acc.sv */
// crossing parity and early-decision state, result register and pipeline advance
`default_nettype none
module pip_acc
  import pip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_ctl_t   s3_ctl,
  input  wire edge_flags_t e_flags,
  input  wire edge_flags_t c_flags,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             inside_res,
  output logic             adv
);

  logic crossing_parity, answer_fixed, fixed_answer;
  logic p1, f1, a1;
  logic p2, f2, a2;
  logic res;
  logic commit;

  // a result can only leave when the output register is free or being taken
  assign adv    = !s3_ctl.valid || !s3_ctl.last || !out_valid || out_ready;
  assign commit = adv && s3_ctl.valid;

  always_comb begin
    p1 = crossing_parity;
    f1 = answer_fixed;
    a1 = fixed_answer;
    if (s3_ctl.has_edge && !answer_fixed && e_flags.hit) begin
      if (e_flags.coll) begin
        f1 = 1'b1;
        a1 = e_flags.on_box;
      end else begin
        p1 = !crossing_parity;
      end
    end
    p2 = p1;
    f2 = f1;
    a2 = a1;
    // closing edge from the last vertex back to the first
    if (s3_ctl.closing && !f1 && c_flags.hit) begin
      if (c_flags.coll) begin
        f2 = 1'b1;
        a2 = c_flags.on_box;
      end else begin
        p2 = !p1;
      end
    end
    if (!s3_ctl.closing) begin
      res = 1'b0;
    end else if (f2) begin
      res = a2;
    end else begin
      res = p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      answer_fixed    <= 1'b0;
      fixed_answer    <= 1'b0;
    end else if (commit) begin
      if (s3_ctl.last) begin
        crossing_parity <= 1'b0;
        answer_fixed    <= 1'b0;
        fixed_answer    <= 1'b0;
      end else begin
        crossing_parity <= p2;
        answer_fixed    <= f2;
        fixed_answer    <= a2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && s3_ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && s3_ctl.last) begin
      inside_res <= res;
    end
  end

endmodule
`default_nettype wire

/* src/point_in_polygon_ray_cast.sv */
// top level: point-in-polygon crossing-number test over a stream of vertices
//
// Each input item carries the query point and one polygon vertex, in order;
// last_vertex marks the final vertex and closes the polygon. Only that item
// yields a result item, inside_res, which is 1 when the point is inside or on
// the boundary. Polygons with fewer than three vertices give 0.
// Items move through a four-register pipeline: vertex register, product
// register, classification register, then the parity update and the result
// register. A result shows on out_valid once its last vertex has reached the
// result register. One item is accepted per cycle while in_ready is high; the
// rate is set by the single parity update at the end of the pipeline.
// When the receiver stalls, items without a result keep flowing; the pipeline
// holds only once a finished result waits and another last vertex reaches the
// end, and in_ready then drops.
// Reset empties the pipeline, clears all per-polygon state and sets ray_end_x
// to 10000. ray_end_x is written over the APB port at byte address 0.
`default_nettype none
module point_in_polygon_ray_cast
  import pip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic                         last_vertex,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              inside_res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_BITS-1:0]         paddr,
  input  wire logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]              prdata,
  output logic                              pready
);

  logic signed [RAY_BITS-1:0]   ray_end_x;
  logic [ADDR_BITS-3:0]         reg_idx;
  logic                         adv;
  item_ctl_t                    s1_ctl, s2_ctl, s3_ctl;
  logic signed [COORD_BITS-1:0] s1_px, s1_py, s1_vx, s1_vy;
  logic signed [COORD_BITS-1:0] s1_prev_x, s1_prev_y, s1_first_x, s1_first_y;
  edge_flags_t                  e_flags, c_flags;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign prdata  = (reg_idx == REG_RAY_END_X) ? DATA_BITS'(ray_end_x) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_end_x <= RAY_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_RAY_END_X)) begin
      ray_end_x <= pwdata[RAY_BITS-1:0];
    end
  end

  assign in_ready = adv;

  pip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .point_x    (point_x),
    .point_y    (point_y),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .last_vertex(last_vertex),
    .s1_ctl     (s1_ctl),
    .s1_px      (s1_px),
    .s1_py      (s1_py),
    .s1_vx      (s1_vx),
    .s1_vy      (s1_vy),
    .s1_prev_x  (s1_prev_x),
    .s1_prev_y  (s1_prev_y),
    .s1_first_x (s1_first_x),
    .s1_first_y (s1_first_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  // edge from the previous vertex to this one
  pip_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk  (clk),
    .adv  (adv),
    .ax   (s1_prev_x),
    .ay   (s1_prev_y),
    .bx   (s1_vx),
    .by   (s1_vy),
    .px   (s1_px),
    .py   (s1_py),
    .ex   (ray_end_x),
    .flags(e_flags)
  );

  // closing edge back to the first vertex
  pip_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_close (
    .clk  (clk),
    .adv  (adv),
    .ax   (s1_vx),
    .ay   (s1_vy),
    .bx   (s1_first_x),
    .by   (s1_first_y),
    .px   (s1_px),
    .py   (s1_py),
    .ex   (ray_end_x),
    .flags(c_flags)
  );

  pip_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .s3_ctl    (s3_ctl),
    .e_flags   (e_flags),
    .c_flags   (c_flags),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .inside_res(inside_res),
    .adv       (adv)
  );

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_ctl.valid && s3_ctl.last))
    else $error("result raised without a last vertex at the pipeline end");

  a_short_polygon: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_ctl.valid && s3_ctl.last && !s3_ctl.closing) |=> !inside_res)
    else $error("short polygon gave a nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_ctl.valid && !s2_ctl.valid && !s3_ctl.valid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
